// File: hw/rtl/slte_pkg.sv
// Shared codes, widths and controller/datapath handshake types for the slot list table.
package slte_pkg;

    localparam int REQ_W  = 4;
    localparam int SLOT_W = 4;
    localparam int AMT_W  = 8;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 4;
    localparam int CNT_W  = 4;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 40;

    localparam logic [REQ_W-1:0] REQ_CREATE       = 4'd0;
    localparam logic [REQ_W-1:0] REQ_APPEND       = 4'd1;
    localparam logic [REQ_W-1:0] REQ_POP          = 4'd2;
    localparam logic [REQ_W-1:0] REQ_DELETE       = 4'd3;
    localparam logic [REQ_W-1:0] REQ_RESIZE       = 4'd4;
    localparam logic [REQ_W-1:0] REQ_COUNT        = 4'd5;
    localparam logic [REQ_W-1:0] REQ_READ         = 4'd6;
    localparam logic [REQ_W-1:0] REQ_READ_SORT    = 4'd7;
    localparam logic [REQ_W-1:0] REQ_RD_ALL       = 4'd8;
    localparam logic [REQ_W-1:0] REQ_RD_ALL_SORT  = 4'd9;

    localparam logic [ST_W-1:0] ST_OK           = 4'd0;
    localparam logic [ST_W-1:0] ST_BAD_POS      = 4'd1;
    localparam logic [ST_W-1:0] ST_BAD_SIZE     = 4'd2;
    localparam logic [ST_W-1:0] ST_EXISTS       = 4'd3;
    localparam logic [ST_W-1:0] ST_NO_STORAGE   = 4'd4;
    localparam logic [ST_W-1:0] ST_FULL         = 4'd5;
    localparam logic [ST_W-1:0] ST_NO_LIST      = 4'd6;
    localparam logic [ST_W-1:0] ST_EMPTY        = 4'd7;
    localparam logic [ST_W-1:0] ST_NOT_FOUND    = 4'd8;
    localparam logic [ST_W-1:0] ST_ALL_EMPTY    = 4'd9;
    localparam logic [ST_W-1:0] ST_BAD_NEW_SIZE = 4'd10;

    localparam logic [1:0] K_SINGLE = 2'd0;
    localparam logic [1:0] K_DELETE = 2'd1;
    localparam logic [1:0] K_READ   = 2'd2;
    localparam logic [1:0] K_SORT   = 2'd3;

    typedef struct packed {
        logic load;
        logic wstart;
        logic wadv;
        logic commit;
        logic push_data;
        logic sort_push;
        logic sh_init;
        logic sh_rd;
        logic sh_wr;
        logic del_done;
    } t_ctl_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       out_free;
        logic       wact;
        logic       pos_valid;
        logic       found;
        logic       sh_more;
        logic       is_last;
    } t_ctl_sts;

endpackage

// File: hw/rtl/slte_ctrl.sv
// Request sequencer: steps each request through decode, scans, shifts and result pushes.
module slte_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    output slte_pkg::t_ctl_cmd  o_cmd,
    input  slte_pkg::t_ctl_sts  i_sts
);
    import slte_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_SINGLE = 4'd2;
    localparam logic [3:0] S_DSCAN  = 4'd3;
    localparam logic [3:0] S_DPOST  = 4'd4;
    localparam logic [3:0] S_DSHR   = 4'd5;
    localparam logic [3:0] S_DSHW   = 4'd6;
    localparam logic [3:0] S_DDONE  = 4'd7;
    localparam logic [3:0] S_RADV   = 4'd8;
    localparam logic [3:0] S_ROUT   = 4'd9;
    localparam logic [3:0] S_SSCAN  = 4'd10;
    localparam logic [3:0] S_SOUT   = 4'd11;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                unique case (i_sts.kind)
                    K_DELETE: begin
                        o_cmd.wstart = 1'b1;
                        n_state      = S_DSCAN;
                    end
                    K_READ: begin
                        o_cmd.wstart = 1'b1;
                        n_state      = S_RADV;
                    end
                    K_SORT: begin
                        o_cmd.wstart = 1'b1;
                        n_state      = S_SSCAN;
                    end
                    default: n_state = S_SINGLE;
                endcase
            end
            S_SINGLE: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_DSCAN: begin
                if (i_sts.wact) o_cmd.wadv = 1'b1;
                else n_state = S_DPOST;
            end
            S_DPOST: begin
                if (i_sts.found) begin
                    o_cmd.sh_init = 1'b1;
                    n_state       = S_DSHR;
                end else begin
                    n_state = S_DDONE;
                end
            end
            S_DSHR: begin
                if (i_sts.sh_more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_DSHW;
                end else begin
                    n_state = S_DDONE;
                end
            end
            S_DSHW: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_DSHR;
            end
            S_DDONE: begin
                if (i_sts.out_free) begin
                    o_cmd.del_done = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_RADV: begin
                // skip empty slots until an element is read
                o_cmd.wadv = 1'b1;
                if (i_sts.pos_valid) n_state = S_ROUT;
            end
            S_ROUT: begin
                if (i_sts.out_free) begin
                    o_cmd.push_data = 1'b1;
                    n_state         = i_sts.is_last ? S_IDLE : S_RADV;
                end
            end
            S_SSCAN: begin
                if (i_sts.wact) o_cmd.wadv = 1'b1;
                else n_state = S_SOUT;
            end
            S_SOUT: begin
                if (i_sts.out_free) begin
                    o_cmd.sort_push = 1'b1;
                    if (i_sts.is_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.wstart = 1'b1;
                        n_state      = S_SSCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

endmodule

// File: hw/rtl/slte_dp.sv
// Datapath: list metadata, element memory, walker, compare unit and output word register.
module slte_dp #(
    parameter int NUM_SLOTS = 8,
    parameter int SLOT_CAP  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [slte_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic [slte_pkg::REQ_W-1:0]          i_s_tuser,
    input  slte_pkg::t_ctl_cmd                  i_cmd,
    output slte_pkg::t_ctl_sts                  o_sts,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [slte_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);
    import slte_pkg::*;

    localparam int DEPTH = NUM_SLOTS * SLOT_CAP;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int KW    = VAL_W + AW;

    function automatic logic [AW-1:0] f_addr(input logic [SW-1:0] s, input logic [3:0] o);
        f_addr = AW'(32'(s) * SLOT_CAP + 32'(o));
    endfunction

    // request word
    logic [REQ_W-1:0]  r_req;
    logic [SLOT_W-1:0] r_slot;
    logic [AMT_W-1:0]  r_amt;
    logic [VAL_W-1:0]  r_val;

    // table metadata
    logic              r_exists [NUM_SLOTS];
    logic [CNT_W-1:0]  r_cap    [NUM_SLOTS];
    logic [CNT_W-1:0]  r_cnt    [NUM_SLOTS];
    logic [TW-1:0]     r_total;

    logic [VAL_W-1:0]  r_mem [DEPTH];
    logic [VAL_W-1:0]  r_rdata;
    logic              r_rd_vld;
    logic [AW-1:0]     r_rd_addr;
    logic [3:0]        r_rd_off;

    logic [SW-1:0]     r_ws;
    logic [3:0]        r_wi;
    logic              r_wact;
    logic              r_found;
    logic [3:0]        r_hit;
    logic              r_have_best;
    logic [KW-1:0]     r_best_key;
    logic [KW-1:0]     r_last_key;
    logic [TW-1:0]     r_k;

    logic              r_o_valid;
    logic [ST_W-1:0]   r_o_status;
    logic [CNT_W-1:0]  r_o_count;
    logic [VAL_W-1:0]  r_o_data;
    logic              r_o_dvalid;
    logic              r_o_last;

    logic              pos_bad;
    logic [SW-1:0]     s_idx;
    logic              ex;
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  cnt;
    logic              is_all;
    logic              is_sort;
    logic [TW-1:0]     n_sel;
    logic [CNT_W-1:0]  wcnt;
    logic              pos_valid;
    logic [KW-1:0]     rd_key;
    logic              take_best;
    logic signed [8:0] ncap;
    logic [CNT_W-1:0]  ncap4;

    logic [1:0]        d_kind;
    logic [ST_W-1:0]   d_status;
    logic [CNT_W-1:0]  d_count;
    logic              d_mk;
    logic              d_app;
    logic              d_pop;
    logic              d_rsz;

    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [VAL_W-1:0]  mem_wd;
    logic              mem_re;
    logic [AW-1:0]     mem_ra;
    logic              push;
    logic              out_free;

    assign pos_bad   = (r_slot == '0) || (r_slot > SLOT_W'(NUM_SLOTS));
    assign s_idx     = pos_bad ? '0 : SW'(r_slot - 4'd1);
    assign ex        = r_exists[s_idx];
    assign cap       = r_cap[s_idx];
    assign cnt       = r_cnt[s_idx];
    assign is_all    = (r_req == REQ_RD_ALL) || (r_req == REQ_RD_ALL_SORT);
    assign is_sort   = (r_req == REQ_READ_SORT) || (r_req == REQ_RD_ALL_SORT);
    assign n_sel     = is_all ? r_total : TW'(cnt);
    assign wcnt      = r_cnt[r_ws];
    assign pos_valid = r_wact && (r_wi < wcnt);
    // flip the sign bit so an unsigned compare orders signed values; address breaks ties
    assign rd_key    = {~r_rdata[VAL_W-1], r_rdata[VAL_W-2:0], r_rd_addr};
    assign take_best = ((r_k == '0) || (rd_key > r_last_key))
                       && (!r_have_best || (rd_key < r_best_key));
    assign ncap      = $signed({5'b0, cap}) + $signed({r_amt[AMT_W-1], r_amt});
    assign ncap4     = ncap[3:0];
    assign out_free  = !r_o_valid || i_m_tready;
    assign push      = i_cmd.commit || i_cmd.del_done || i_cmd.push_data || i_cmd.sort_push;

    always_comb begin
        d_kind   = K_SINGLE;
        d_status = ST_OK;
        d_count  = '0;
        d_mk     = 1'b0;
        d_app    = 1'b0;
        d_pop    = 1'b0;
        d_rsz    = 1'b0;
        if (is_all) begin
            if (r_total == '0) d_status = ST_ALL_EMPTY;
            else d_kind = (r_req == REQ_RD_ALL_SORT) ? K_SORT : K_READ;
        end else if (r_req <= REQ_READ_SORT) begin
            if (pos_bad) begin
                d_status = ST_BAD_POS;
            end else begin
                unique case (r_req)
                    REQ_CREATE: begin
                        if ($signed(r_amt) < 8'sd1) d_status = ST_BAD_SIZE;
                        else if (ex) d_status = ST_EXISTS;
                        else if ($signed(r_amt) > $signed(AMT_W'(SLOT_CAP)))
                            d_status = ST_NO_STORAGE;
                        else d_mk = 1'b1;
                    end
                    REQ_APPEND: begin
                        if (!ex) d_status = ST_NO_LIST;
                        else if (cnt >= cap) d_status = ST_FULL;
                        else d_app = 1'b1;
                    end
                    REQ_POP: begin
                        if (!ex) d_status = ST_NO_LIST;
                        else if (cnt == '0) d_status = ST_EMPTY;
                        else d_pop = 1'b1;
                    end
                    REQ_DELETE: begin
                        if (!ex) d_status = ST_NO_LIST;
                        else if (cnt == '0) d_status = ST_NOT_FOUND;
                        else d_kind = K_DELETE;
                    end
                    REQ_RESIZE: begin
                        if (!ex) d_status = ST_NO_LIST;
                        else if (ncap < 9'sd1) d_status = ST_BAD_NEW_SIZE;
                        else if (ncap > $signed(9'(SLOT_CAP))) d_status = ST_NO_STORAGE;
                        else d_rsz = 1'b1;
                    end
                    REQ_COUNT: begin
                        if (!ex) d_status = ST_NO_LIST;
                        else if (cnt == '0) d_status = ST_EMPTY;
                        else d_count = cnt;
                    end
                    REQ_READ: begin
                        if (!ex || cnt == '0) d_status = ST_NO_LIST;
                        else d_kind = K_READ;
                    end
                    REQ_READ_SORT: begin
                        if (!ex) d_status = ST_NO_LIST;
                        else if (cnt != '0) d_kind = K_SORT;
                    end
                    default: d_status = ST_OK;
                endcase
            end
        end
    end

    assign mem_we = (i_cmd.commit && d_app) || i_cmd.sh_wr;
    assign mem_wa = i_cmd.sh_wr ? f_addr(s_idx, r_wi) : f_addr(s_idx, cnt);
    assign mem_wd = i_cmd.sh_wr ? r_rdata : r_val;
    assign mem_re = (i_cmd.wadv && pos_valid) || i_cmd.sh_rd;
    assign mem_ra = i_cmd.sh_rd ? f_addr(s_idx, r_wi + 4'd1) : f_addr(r_ws, r_wi);

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req  <= i_s_tuser;
            r_slot <= i_s_tdata[3:0];
            r_amt  <= i_s_tdata[11:4];
            r_val  <= i_s_tdata[43:12];
        end
        if (i_cmd.wadv && pos_valid) begin
            r_rd_addr <= f_addr(r_ws, r_wi);
            r_rd_off  <= r_wi;
        end
        if (r_rd_vld && r_req == REQ_DELETE && !r_found && r_rdata == r_val) r_hit <= r_rd_off;
        if (r_rd_vld && is_sort && take_best) r_best_key <= rd_key;
        if (i_cmd.sort_push) r_last_key <= r_best_key;
        if (i_cmd.commit) begin
            r_o_status <= d_status;
            r_o_count  <= d_count;
            r_o_data   <= '0;
            r_o_dvalid <= 1'b0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.del_done) begin
            r_o_status <= r_found ? ST_OK : ST_NOT_FOUND;
            r_o_count  <= '0;
            r_o_data   <= '0;
            r_o_dvalid <= 1'b0;
            r_o_last   <= 1'b1;
        end else if (i_cmd.push_data || i_cmd.sort_push) begin
            r_o_status <= ST_OK;
            r_o_count  <= '0;
            r_o_data   <= i_cmd.push_data ? r_rdata
                        : {~r_best_key[KW-1], r_best_key[KW-2:AW]};
            r_o_dvalid <= 1'b1;
            r_o_last   <= o_sts.is_last;
        end
    end

    // control and table state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_exists[i] <= 1'b0;
                r_cap[i]    <= '0;
                r_cnt[i]    <= '0;
            end
            r_total     <= '0;
            r_rd_vld    <= 1'b0;
            r_ws        <= '0;
            r_wi        <= '0;
            r_wact      <= 1'b0;
            r_found     <= 1'b0;
            r_have_best <= 1'b0;
            r_k         <= '0;
            r_o_valid   <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.wadv && pos_valid;
            if (i_cmd.load) r_k <= '0;
            if (i_cmd.push_data || i_cmd.sort_push) r_k <= TW'(r_k + 1'b1);

            if (i_cmd.commit) begin
                if (d_mk) begin
                    r_exists[s_idx] <= 1'b1;
                    r_cap[s_idx]    <= r_amt[3:0];
                    r_cnt[s_idx]    <= '0;
                end
                if (d_app) begin
                    r_cnt[s_idx] <= cnt + 4'd1;
                    r_total      <= TW'(r_total + 1'b1);
                end
                if (d_pop) begin
                    r_cnt[s_idx] <= cnt - 4'd1;
                    r_total      <= TW'(r_total - 1'b1);
                end
                if (d_rsz) begin
                    r_cap[s_idx] <= ncap4;
                    // clip the count to the new capacity
                    if (cnt > ncap4) begin
                        r_cnt[s_idx] <= ncap4;
                        r_total      <= TW'(r_total - TW'(cnt - ncap4));
                    end
                end
            end
            if (i_cmd.del_done && r_found) begin
                r_cnt[s_idx] <= cnt - 4'd1;
                r_total      <= TW'(r_total - 1'b1);
            end

            // each scan pass starts with wstart, which also drops the held best
            if (i_cmd.wstart) begin
                r_ws        <= is_all ? '0 : s_idx;
                r_wi        <= '0;
                r_wact      <= 1'b1;
                r_found     <= 1'b0;
                r_have_best <= 1'b0;
            end else if (i_cmd.wadv) begin
                if ((r_wi + 4'd1) < wcnt) begin
                    r_wi <= r_wi + 4'd1;
                end else if (is_all && r_ws != SW'(NUM_SLOTS - 1)) begin
                    r_ws <= r_ws + 1'b1;
                    r_wi <= '0;
                end else begin
                    r_wact <= 1'b0;
                end
            end else if (i_cmd.sh_init) begin
                r_wi <= r_hit;
            end else if (i_cmd.sh_wr) begin
                r_wi <= r_wi + 4'd1;
            end

            if (r_rd_vld && r_req == REQ_DELETE && !r_found && r_rdata == r_val)
                r_found <= 1'b1;
            if (r_rd_vld && is_sort && take_best) r_have_best <= 1'b1;

            if (push) r_o_valid <= 1'b1;
            else if (i_m_tready) r_o_valid <= 1'b0;
        end
    end

    assign o_sts.kind      = d_kind;
    assign o_sts.out_free  = out_free;
    assign o_sts.wact      = r_wact;
    assign o_sts.pos_valid = pos_valid;
    assign o_sts.found     = r_found;
    assign o_sts.sh_more   = (r_wi + 4'd1) < cnt;
    assign o_sts.is_last   = (TW'(r_k + 1'b1) == n_sel);

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {r_o_data, r_o_count, r_o_status};
    assign o_m_tuser  = r_o_dvalid;
    assign o_m_tlast  = r_o_last;

endmodule

// File: hw/rtl/slot_list_table_engine.sv
// Slot list table top level: one request at a time, words through a registered output stage.
// Simple requests present a single word; in-order reads skip empty slots between words; delete
// scans the list, then shifts each later element down with a read state and a write state.
// Sorted reads rescan the walked range once per word, set by the single read port of the
// element memory. Next request is taken once the final word is loaded into the output
// register. Reset (i_rst_n low, synchronous) clears all lists; the element memory is not
// cleared and is only read below each list's count.
module slot_list_table_engine #(
    parameter int NUM_SLOTS = 8,
    parameter int SLOT_CAP  = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // slot[3:0], size_amount[11:4], value[43:12], zero pad[47:44]
    input  logic [slte_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // req_type[3:0]
    input  logic [slte_pkg::REQ_W-1:0]          i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // status[3:0], count[7:4], data_value[39:8]
    output logic [slte_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    // data_valid[0]
    output logic                                o_m_tuser,
    output logic                                o_m_tlast
);
    import slte_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    slte_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    slte_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .SLOT_CAP  (SLOT_CAP)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit || cmd.del_done || cmd.push_data || cmd.sort_push) |-> sts.out_free)
        else $error("word pushed while output register is stalled");

    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second request taken while one is in work");

    a_walk_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.wadv |-> sts.wact)
        else $error("walker advanced while idle");

    a_last_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.commit || cmd.del_done) |=> (o_m_tvalid && o_m_tlast))
        else $error("single-word result not marked last");

endmodule

// File: tb/sv/slot_list_table_engine_tb.sv
// Testbench for the slot list table: directed table, then random requests, against a predictor.
module slot_list_table_engine_tb;
    import slte_pkg::*;

    localparam int NSLOT = 8;
    localparam int CAP = 8;

    typedef struct {
        logic [ST_W-1:0]  status;
        logic [CNT_W-1:0] count;
        logic [VAL_W-1:0] data;
        logic             dvalid;
        logic             last;
    } t_list_word;

    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [SLOT_W-1:0] slot;
        int                amt;
        logic [VAL_W-1:0]  value;
        int                want_status;   // -1: take the predictor's words
        int                want_count;
    } t_table_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic [REQ_W-1:0]       i_s_tuser = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tuser;
    logic                   o_m_tlast;

    // Predictor state
    logic             list_live[NSLOT];
    int               list_cap[NSLOT];
    int               list_len[NSLOT];
    logic [VAL_W-1:0] elems[NSLOT*CAP];

    t_list_word expected_words[$];
    int         errors = 0;

    slot_list_table_engine u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #200000000;
        $display("tb: failure");
        $finish;
    end

    task automatic push_single(input logic [ST_W-1:0] st, input int cnt);
        t_list_word w;
        w.status = st;
        w.count = cnt[CNT_W-1:0];
        w.data = '0;
        w.dvalid = 1'b0;
        w.last = 1'b1;
        expected_words.push_back(w);
    endtask

    task automatic push_elements(input logic [VAL_W-1:0] buf_in[$], input logic sorted);
        logic [VAL_W-1:0] b[$];
        logic [VAL_W-1:0] v;
        t_list_word w;
        int j;
        b = buf_in;
        if (sorted) begin
            for (int i = 1; i < b.size(); i++) begin
                v = b[i];
                j = i - 1;
                while (j >= 0 && $signed(b[j]) > $signed(v)) begin
                    b[j+1] = b[j];
                    j--;
                end
                b[j+1] = v;
            end
        end
        foreach (b[i]) begin
            w.status = ST_OK;
            w.count = '0;
            w.data = b[i];
            w.dvalid = 1'b1;
            w.last = (i == b.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    // Apply one request to the shadow table and queue the words it should produce.
    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot,
                                   input int amt, input logic [VAL_W-1:0] value);
        logic [VAL_W-1:0] b[$];
        int s, base, n, hit, ncap;
        s = int'(slot) - 1;
        base = s * CAP;
        if (req > REQ_RD_ALL_SORT) begin
            push_single(ST_OK, 0);
            return;
        end
        if (req == REQ_RD_ALL || req == REQ_RD_ALL_SORT) begin
            for (int k = 0; k < NSLOT; k++)
                if (list_live[k])
                    for (int i = 0; i < list_len[k]; i++) b.push_back(elems[k*CAP+i]);
            if (b.size() == 0) push_single(ST_ALL_EMPTY, 0);
            else push_elements(b, req == REQ_RD_ALL_SORT);
            return;
        end
        if (slot < 1 || slot > NSLOT) begin
            push_single(ST_BAD_POS, 0);
            return;
        end
        n = list_len[s];
        case (req)
            REQ_CREATE: begin
                if (amt < 1) push_single(ST_BAD_SIZE, 0);
                else if (list_live[s]) push_single(ST_EXISTS, 0);
                else if (amt > CAP) push_single(ST_NO_STORAGE, 0);
                else begin
                    list_live[s] = 1'b1;
                    list_cap[s] = amt;
                    list_len[s] = 0;
                    push_single(ST_OK, 0);
                end
            end
            REQ_APPEND: begin
                if (!list_live[s]) push_single(ST_NO_LIST, 0);
                else if (n >= list_cap[s]) push_single(ST_FULL, 0);
                else begin
                    elems[base+n] = value;
                    list_len[s] = n + 1;
                    push_single(ST_OK, 0);
                end
            end
            REQ_POP: begin
                if (!list_live[s]) push_single(ST_NO_LIST, 0);
                else if (n == 0) push_single(ST_EMPTY, 0);
                else begin
                    list_len[s] = n - 1;
                    push_single(ST_OK, 0);
                end
            end
            REQ_DELETE: begin
                hit = -1;
                if (!list_live[s]) push_single(ST_NO_LIST, 0);
                else begin
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && elems[base+i] == value) hit = i;
                    if (hit < 0) push_single(ST_NOT_FOUND, 0);
                    else begin
                        for (int i = hit; i < n - 1; i++) elems[base+i] = elems[base+i+1];
                        list_len[s] = n - 1;
                        push_single(ST_OK, 0);
                    end
                end
            end
            REQ_RESIZE: begin
                if (!list_live[s]) push_single(ST_NO_LIST, 0);
                else begin
                    ncap = list_cap[s] + amt;
                    if (ncap < 1) push_single(ST_BAD_NEW_SIZE, 0);
                    else if (ncap > CAP) push_single(ST_NO_STORAGE, 0);
                    else begin
                        list_cap[s] = ncap;
                        if (n > ncap) list_len[s] = ncap;
                        push_single(ST_OK, 0);
                    end
                end
            end
            REQ_COUNT: begin
                if (!list_live[s]) push_single(ST_NO_LIST, 0);
                else if (n == 0) push_single(ST_EMPTY, 0);
                else push_single(ST_OK, n);
            end
            REQ_READ: begin
                if (!list_live[s] || n == 0) push_single(ST_NO_LIST, 0);
                else begin
                    for (int i = 0; i < n; i++) b.push_back(elems[base+i]);
                    push_elements(b, 1'b0);
                end
            end
            default: begin
                if (!list_live[s]) push_single(ST_NO_LIST, 0);
                else if (n == 0) push_single(ST_OK, 0);
                else begin
                    for (int i = 0; i < n; i++) b.push_back(elems[base+i]);
                    push_elements(b, 1'b1);
                end
            end
        endcase
    endtask

    function automatic int draw_gap(input logic calm);
        if (calm) return 0;
        return $urandom_range(0, 4);
    endfunction

    // Hold one request on the slave side until accepted, then predict it.
    task automatic send_request(input t_table_row r, input logic calm);
        int gap;
        int before_n;
        gap = draw_gap(calm);
        if (gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = r.req;
        i_s_tdata = {4'b0, r.value, r.amt[AMT_W-1:0], r.slot};
        do @(posedge i_clk); while (!o_s_tready);
        before_n = expected_words.size();
        predict_request(r.req, r.slot, r.amt, r.value);
        if (r.want_status >= 0) begin
            expected_words[before_n].status = r.want_status[ST_W-1:0];
            expected_words[before_n].count = r.want_count[CNT_W-1:0];
        end
        @(negedge i_clk);
    endtask

    // Master side: stall at random per word and compare each word taken.
    initial begin
        t_list_word w;
        int stall;
        logic [VAL_W-1:0] got_data;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            got_data = o_m_tdata[39:8];
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word status=%0d data=%h last=%b", $time,
                         o_m_tdata[3:0], got_data, o_m_tlast);
                errors++;
            end else begin
                w = expected_words.pop_front();
                if (o_m_tdata[3:0] !== w.status || o_m_tdata[7:4] !== w.count ||
                    got_data !== w.data || o_m_tuser !== w.dvalid || o_m_tlast !== w.last) begin
                    $display("%0t: mismatch expected st=%0d cnt=%0d data=%h dv=%b last=%b",
                             $time, w.status, w.count, w.data, w.dvalid, w.last);
                    $display("%0t:          actual   st=%0d cnt=%0d data=%h dv=%b last=%b",
                             $time, o_m_tdata[3:0], o_m_tdata[7:4], got_data, o_m_tuser,
                             o_m_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_table_row dir_rows[25];
        t_table_row r;
        logic calm;
        int s, n, pick;
        for (int k = 0; k < NSLOT; k++) begin
            list_live[k] = 1'b0;
            list_cap[k] = 0;
            list_len[k] = 0;
        end
        dir_rows = '{
            '{REQ_COUNT,       4'd1,  0,   32'h0,        ST_NO_LIST,      0},
            '{REQ_RD_ALL,      4'd0,  0,   32'h0,        ST_ALL_EMPTY,    0},
            '{REQ_CREATE,      4'd0,  3,   32'h0,        ST_BAD_POS,      0},
            '{REQ_CREATE,      4'd15, 3,   32'h0,        ST_BAD_POS,      0},
            '{REQ_CREATE,      4'd1,  0,   32'h0,        ST_BAD_SIZE,     0},
            '{REQ_CREATE,      4'd1,  -64, 32'h0,        ST_BAD_SIZE,     0},
            '{REQ_CREATE,      4'd1,  64,  32'h0,        ST_NO_STORAGE,   0},
            '{REQ_CREATE,      4'd1,  2,   32'h0,        ST_OK,           0},
            '{REQ_CREATE,      4'd1,  2,   32'h0,        ST_EXISTS,       0},
            '{REQ_READ_SORT,   4'd1,  0,   32'h0,        ST_OK,           0},
            '{REQ_READ,        4'd1,  0,   32'h0,        ST_NO_LIST,      0},
            '{REQ_COUNT,       4'd1,  0,   32'h0,        ST_EMPTY,        0},
            '{REQ_POP,         4'd1,  0,   32'h0,        ST_EMPTY,        0},
            '{REQ_DELETE,      4'd1,  0,   32'h5,        ST_NOT_FOUND,    0},
            '{REQ_APPEND,      4'd1,  0,   32'h7fffffff, ST_OK,           0},
            '{REQ_APPEND,      4'd1,  0,   32'h80000000, ST_OK,           0},
            '{REQ_APPEND,      4'd1,  0,   32'h1,        ST_FULL,         0},
            '{REQ_COUNT,       4'd1,  0,   32'h0,        ST_OK,           2},
            '{REQ_READ_SORT,   4'd1,  0,   32'h0,        -1,              0},
            '{REQ_RESIZE,      4'd1,  -64, 32'h0,        ST_BAD_NEW_SIZE, 0},
            '{REQ_RESIZE,      4'd1,  64,  32'h0,        ST_NO_STORAGE,   0},
            '{REQ_POP,         4'd2,  0,   32'h0,        ST_NO_LIST,      0},
            '{REQ_CREATE,      4'd8,  8,   32'hffffffff, ST_OK,           0},
            '{4'd15,           4'd3,  0,   32'h0,        ST_OK,           0},
            '{REQ_RD_ALL_SORT, 4'd0,  0,   32'h0,        -1,              0}
        };
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        foreach (dir_rows[i]) send_request(dir_rows[i], 1'b0);
        // Shrink with clipping, then delete the surviving element.
        send_request('{REQ_RESIZE, 4'd1, -1, 32'h0, ST_OK, 0}, 1'b0);
        send_request('{REQ_DELETE, 4'd1, 0, 32'h7fffffff, ST_OK, 0}, 1'b0);

        calm = 1'b0;
        for (int it = 0; it < 450; it++) begin
            if (it % 60 == 0) calm = ($urandom_range(0, 2) == 0);
            r.want_status = -1;
            r.want_count = 0;
            r.value = $urandom();
            if ($urandom_range(0, 3) == 0) r.value = $urandom_range(0, 7);
            r.req = ($urandom_range(0, 29) == 0) ? 4'($urandom_range(10, 15))
                                                 : 4'($urandom_range(0, 9));
            if ($urandom_range(0, 2) == 0 && r.req < 10)
                r.req = ($urandom_range(0, 1) == 0) ? REQ_APPEND : REQ_CREATE;
            r.slot = ($urandom_range(0, 11) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(1, NSLOT));
            r.amt = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 128) - 64
                                                : $urandom_range(1, CAP);
            if (r.req == REQ_RESIZE && $urandom_range(0, 3) != 0)
                r.amt = $urandom_range(0, 6) - 3;
            if (r.req == REQ_DELETE && r.slot >= 1 && r.slot <= NSLOT) begin
                s = int'(r.slot) - 1;
                n = list_len[s];
                if (n > 0 && $urandom_range(0, 3) != 0) begin
                    pick = $urandom_range(0, n - 1);
                    r.value = elems[s*CAP+pick];
                end
            end
            // Keep a few lists cycling through create and teardown-like churn.
            if (r.req == REQ_POP && $urandom_range(0, 1) == 0) r.req = REQ_DELETE;
            send_request(r, calm);
        end
        i_s_tvalid = 1'b0;

        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/slte_pkg.sv
hw/rtl/slte_ctrl.sv
hw/rtl/slte_dp.sv
hw/rtl/slot_list_table_engine.sv
tb/sv/slot_list_table_engine_tb.sv
